>>> src/mandelbrot_pixel_escape_macros.svh
// Assertion macros used by the checker file mpe_checker.sv.
`ifndef MANDELBROT_PIXEL_ESCAPE_MACROS_SVH
`define MANDELBROT_PIXEL_ESCAPE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mpe_pkg.sv
package mpe_pkg;

    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;
    localparam int DIM_W      = 13;
    localparam int LIM_W      = 16;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_W      = 12;
    localparam int DEN_W      = 12;
    localparam int DIG_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 2'd2;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH     = 13'd200;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT    = 13'd100;
    localparam logic [LIM_W-1:0] RST_ITERATION_LIMIT = 16'd30000;

    typedef struct packed {
        logic [COL_W-1:0] pixel_col;
        logic [ROW_W-1:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic             inside_set;
        logic [CNT_W-1:0] escape_count;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_MUL,
        ST_STORE,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_ZR_SQ,
        OP_ZI_SQ,
        OP_ZR_ZI
    } t_op;

endpackage

>>> src/mpe_stream_if.sv
interface mpe_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/mandelbrot_pixel_escape.sv
// A restoring divider first computes c; each escape check then runs three digit-serial
// multiplications over ND, the 32-bit digits of a Q4 word (one digit while FRAC_BITS <= 28).
// The checks number escape_count+1 on escape, escape_count when the limit stops the loop.
// One pixel at a time: the shared multiplier sets the pace; a new pixel is taken while
// the previous result waits in the output register.
// Reset (synchronous, active low) idles the sequencer, empties the output and restores config.
module mandelbrot_pixel_escape #(
    parameter int FRAC_BITS = 28
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mpe_stream_if.sink   i_pix,
    mpe_stream_if.source o_res,
    mpe_stream_if.sink   i_cfg
);

    localparam int Q_W   = FRAC_BITS + 4;
    localparam int SQ_W  = Q_W + 4;
    localparam int EXT_W = Q_W + 5;
    localparam int DIG_W = mpe_pkg::DIG_W;
    localparam int ND    = (Q_W + DIG_W - 1) / DIG_W;
    localparam int MAG_W = ND * DIG_W;
    localparam int ACC_W = 2 * MAG_W;
    localparam int IW    = (ND > 1) ? $clog2(ND) : 1;
    localparam int SH_W  = IW + 1;
    localparam int NUM_W = mpe_pkg::NUM_W;
    localparam int DEN_W = mpe_pkg::DEN_W;
    localparam int DIM_W = mpe_pkg::DIM_W;
    localparam int CNT_W = mpe_pkg::CNT_W;
    localparam int DVD_W = NUM_W + FRAC_BITS;
    localparam int DC_W  = $clog2(DVD_W);

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [SQ_W:0]         FOUR  = (SQ_W+1)'(4) << FRAC_BITS;

    function automatic logic [MAG_W-1:0] f_mag(input logic signed [Q_W-1:0] x);
        logic [Q_W-1:0] m;
        m = x[Q_W-1] ? -x : x;
        return MAG_W'(m);
    endfunction

    function automatic logic signed [Q_W-1:0] f_sat(input logic signed [EXT_W-1:0] v);
        logic ovf;
        ovf = (v[EXT_W-1:Q_W-1] != '0) && (v[EXT_W-1:Q_W-1] != '1);
        if (ovf) begin
            return v[EXT_W-1] ? Q_MIN : Q_MAX;
        end
        return v[Q_W-1:0];
    endfunction

    mpe_pkg::t_state           r_state, n_state;
    logic [DIM_W-1:0]          r_img_w, r_img_h;
    logic [mpe_pkg::LIM_W-1:0] r_lim;

    logic [DVD_W-1:0]          r_dvd, n_dvd;
    logic [DEN_W-1:0]          r_rem, n_rem;
    logic [DVD_W-1:0]          r_quo, n_quo;
    logic [DC_W-1:0]           r_div_cnt, n_div_cnt;
    logic                      r_div_im, n_div_im;
    logic                      r_re_neg, n_re_neg;
    logic                      r_im_neg, n_im_neg;
    logic [NUM_W-1:0]          r_im_mag, n_im_mag;

    logic signed [Q_W-1:0]     r_cr, n_cr, r_ci, n_ci, r_zr, n_zr, r_zi, n_zi;
    logic signed [SQ_W-1:0]    r_sr, n_sr, r_si, n_si, r_pr, n_pr;

    mpe_pkg::t_op              r_op, n_op;
    logic [MAG_W-1:0]          r_a_mag, n_a_mag, r_b_mag, n_b_mag;
    logic                      r_mneg, n_mneg;
    logic [IW-1:0]             r_ia, n_ia, r_ib, n_ib;
    logic                      r_mul_fin, n_mul_fin;
    logic [2*DIG_W-1:0]        r_pp, n_pp;
    logic [SH_W-1:0]           r_pp_sh, n_pp_sh;
    logic                      r_pp_vld, n_pp_vld;
    logic [ACC_W-1:0]          r_acc, n_acc;
    logic [CNT_W-1:0]          r_cnt, n_cnt;

    logic                      r_out_valid, n_out_valid;
    mpe_pkg::t_result          r_out, n_out;

    logic                      pix_acc, res_take, out_free;
    logic signed [DIM_W-1:0]   d_re, d_im;
    logic [DIM_W-1:0]          m_re, m_im;
    logic [DEN_W-1:0]          den_w, den_h, den;
    logic [DEN_W:0]            rem_sh;
    logic                      div_ge, div_neg, div_ovf;
    logic [DVD_W-1:0]          quo_step;
    logic [Q_W-1:0]            quo_val;
    logic signed [Q_W-1:0]     div_res;
    mpe_pkg::t_op              ld_op;
    logic signed [Q_W-1:0]     ld_a, ld_b;
    logic [DIG_W-1:0]          a_dig, b_dig;
    logic [2*DIG_W-1:0]        pp_prod;
    logic [ACC_W-1:0]          pp_ext, acc_sh;
    logic [SQ_W-1:0]           prod_mag;
    logic signed [SQ_W-1:0]    prod_val;
    logic                      mul_last;
    logic [SQ_W:0]             sq_sum;
    logic                      esc, lim_hit;
    logic [CNT_W-1:0]          cnt_inc;
    logic signed [EXT_W-1:0]   re_ext, im_ext;

    assign pix_acc  = i_pix.valid && i_pix.ready;
    assign res_take = o_res.valid && o_res.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign i_pix.ready   = (r_state == mpe_pkg::ST_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // pixel to signed offset from the image center
    assign d_re = signed'({1'b0, i_pix.payload.pixel_col}) - signed'({1'b0, r_img_w[DIM_W-1:1]});
    assign d_im = signed'({1'b0, i_pix.payload.pixel_row}) - signed'({1'b0, r_img_h[DIM_W-1:1]});
    assign m_re = d_re[DIM_W-1] ? -d_re : d_re;
    assign m_im = d_im[DIM_W-1] ? -d_im : d_im;

    // restoring divider, one quotient bit per cycle
    assign den_w    = (r_img_w[DIM_W-1:2] == '0) ? DEN_W'(1) : DEN_W'(r_img_w[DIM_W-1:2]);
    assign den_h    = (r_img_h[DIM_W-1:1] == '0) ? DEN_W'(1) : r_img_h[DIM_W-1:1];
    assign den      = r_div_im ? den_h : den_w;
    assign rem_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign div_ge   = rem_sh >= {1'b0, den};
    assign quo_step = {r_quo[DVD_W-2:0], div_ge};
    assign div_ovf  = |quo_step[DVD_W-1:FRAC_BITS+3];
    assign quo_val  = quo_step[Q_W-1:0];
    assign div_neg  = r_div_im ? r_im_neg : r_re_neg;
    assign div_res  = div_ovf ? (div_neg ? Q_MIN : Q_MAX)
                              : (div_neg ? -signed'(quo_val) : signed'(quo_val));

    // shared multiplier: one digit product per cycle, registered and then accumulated
    assign a_dig    = DIG_W'(r_a_mag >> (r_ia * DIG_W));
    assign b_dig    = DIG_W'(r_b_mag >> (r_ib * DIG_W));
    assign pp_prod  = a_dig * b_dig;
    assign pp_ext   = ACC_W'(r_pp) << (r_pp_sh * DIG_W);
    assign mul_last = (r_ia == IW'(ND - 1)) && (r_ib == IW'(ND - 1));
    assign acc_sh   = r_acc >> FRAC_BITS;
    assign prod_mag = acc_sh[SQ_W-1:0];
    assign prod_val = r_mneg ? -signed'(prod_mag) : signed'(prod_mag);

    // escape test and z update
    assign sq_sum  = {1'b0, r_sr} + {1'b0, r_si};
    assign esc     = sq_sum >= FOUR;
    assign cnt_inc = r_cnt + 1'b1;
    assign lim_hit = cnt_inc >= r_lim;
    assign re_ext  = EXT_W'(r_sr) - EXT_W'(r_si) + EXT_W'(r_cr);
    assign im_ext  = (EXT_W'(r_pr) <<< 1) + EXT_W'(r_ci);

    always_comb begin
        ld_op = r_op;
        if (r_state == mpe_pkg::ST_STORE) begin
            case (r_op)
                mpe_pkg::OP_ZR_SQ: ld_op = mpe_pkg::OP_ZI_SQ;
                mpe_pkg::OP_ZI_SQ: ld_op = mpe_pkg::OP_ZR_ZI;
                default:           ld_op = mpe_pkg::OP_ZR_SQ;
            endcase
        end
        case (ld_op)
            mpe_pkg::OP_ZR_SQ: begin
                ld_a = r_zr;
                ld_b = r_zr;
            end
            mpe_pkg::OP_ZI_SQ: begin
                ld_a = r_zi;
                ld_b = r_zi;
            end
            default: begin
                ld_a = r_zr;
                ld_b = r_zi;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mpe_pkg::ST_IDLE: begin
                if (pix_acc) n_state = mpe_pkg::ST_DIV;
            end
            mpe_pkg::ST_DIV: begin
                if ((r_div_cnt == '0) && r_div_im) n_state = mpe_pkg::ST_LOAD;
            end
            mpe_pkg::ST_LOAD: begin
                n_state = mpe_pkg::ST_MUL;
            end
            mpe_pkg::ST_MUL: begin
                if (r_mul_fin) n_state = mpe_pkg::ST_STORE;
            end
            mpe_pkg::ST_STORE: begin
                n_state = (r_op == mpe_pkg::OP_ZR_ZI) ? mpe_pkg::ST_CHECK : mpe_pkg::ST_MUL;
            end
            mpe_pkg::ST_CHECK: begin
                n_state = (esc || lim_hit) ? mpe_pkg::ST_DONE : mpe_pkg::ST_LOAD;
            end
            mpe_pkg::ST_DONE: begin
                if (out_free) n_state = mpe_pkg::ST_IDLE;
            end
            default: begin
                n_state = mpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div_cnt   = r_div_cnt;
        n_div_im    = r_div_im;
        n_re_neg    = r_re_neg;
        n_im_neg    = r_im_neg;
        n_im_mag    = r_im_mag;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_sr        = r_sr;
        n_si        = r_si;
        n_pr        = r_pr;
        n_op        = r_op;
        n_a_mag     = r_a_mag;
        n_b_mag     = r_b_mag;
        n_mneg      = r_mneg;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_mul_fin   = r_mul_fin;
        n_pp        = r_pp;
        n_pp_sh     = r_pp_sh;
        n_pp_vld    = r_pp_vld;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (res_take) n_out_valid = 1'b0;

        case (r_state)
            mpe_pkg::ST_IDLE: begin
                if (pix_acc) begin
                    n_re_neg  = d_re[DIM_W-1];
                    n_im_neg  = d_im[DIM_W-1];
                    n_im_mag  = m_im[NUM_W-1:0];
                    n_dvd     = {m_re[NUM_W-1:0], {FRAC_BITS{1'b0}}};
                    n_rem     = '0;
                    n_div_cnt = DC_W'(DVD_W - 1);
                    n_div_im  = 1'b0;
                end
            end
            mpe_pkg::ST_DIV: begin
                n_rem     = DEN_W'(div_ge ? rem_sh - {1'b0, den} : rem_sh);
                n_quo     = quo_step;
                n_dvd     = r_dvd << 1;
                n_div_cnt = r_div_cnt - 1'b1;
                if (r_div_cnt == '0) begin
                    if (!r_div_im) begin
                        n_cr      = div_res;
                        n_div_im  = 1'b1;
                        n_dvd     = {r_im_mag, {FRAC_BITS{1'b0}}};
                        n_rem     = '0;
                        n_div_cnt = DC_W'(DVD_W - 1);
                    end else begin
                        n_ci  = div_res;
                        n_zr  = '0;
                        n_zi  = '0;
                        n_cnt = '0;
                        n_op  = mpe_pkg::OP_ZR_SQ;
                    end
                end
            end
            mpe_pkg::ST_LOAD: begin
                n_a_mag   = f_mag(ld_a);
                n_b_mag   = f_mag(ld_b);
                n_mneg    = ld_a[Q_W-1] ^ ld_b[Q_W-1];
                n_ia      = '0;
                n_ib      = '0;
                n_mul_fin = 1'b0;
                n_pp_vld  = 1'b0;
                n_acc     = '0;
            end
            mpe_pkg::ST_MUL: begin
                n_pp     = pp_prod;
                n_pp_sh  = SH_W'(r_ia) + SH_W'(r_ib);
                n_pp_vld = !r_mul_fin;
                if (!r_mul_fin) begin
                    if (mul_last) begin
                        n_mul_fin = 1'b1;
                    end else if (r_ib == IW'(ND - 1)) begin
                        n_ib = '0;
                        n_ia = r_ia + 1'b1;
                    end else begin
                        n_ib = r_ib + 1'b1;
                    end
                end
                if (r_pp_vld) n_acc = r_acc + pp_ext;
            end
            mpe_pkg::ST_STORE: begin
                case (r_op)
                    mpe_pkg::OP_ZR_SQ: n_sr = prod_val;
                    mpe_pkg::OP_ZI_SQ: n_si = prod_val;
                    default:           n_pr = prod_val;
                endcase
                if (r_op != mpe_pkg::OP_ZR_ZI) begin
                    n_op      = ld_op;
                    n_a_mag   = f_mag(ld_a);
                    n_b_mag   = f_mag(ld_b);
                    n_mneg    = ld_a[Q_W-1] ^ ld_b[Q_W-1];
                    n_ia      = '0;
                    n_ib      = '0;
                    n_mul_fin = 1'b0;
                    n_pp_vld  = 1'b0;
                    n_acc     = '0;
                end
            end
            mpe_pkg::ST_CHECK: begin
                if (!esc) n_cnt = cnt_inc;
                if (!esc && !lim_hit) begin
                    n_zr = f_sat(re_ext);
                    n_zi = f_sat(im_ext);
                    n_op = mpe_pkg::OP_ZR_SQ;
                end
            end
            mpe_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.inside_set   = (r_cnt == r_lim);
                    n_out.escape_count = r_cnt;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= mpe_pkg::RST_IMAGE_WIDTH;
            r_img_h <= mpe_pkg::RST_IMAGE_HEIGHT;
            r_lim   <= mpe_pkg::RST_ITERATION_LIMIT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.payload.index)
                mpe_pkg::REG_IMAGE_WIDTH:     r_img_w <= i_cfg.payload.data[DIM_W-1:0];
                mpe_pkg::REG_IMAGE_HEIGHT:    r_img_h <= i_cfg.payload.data[DIM_W-1:0];
                mpe_pkg::REG_ITERATION_LIMIT: r_lim   <= i_cfg.payload.data;
                default: begin
                    r_lim <= r_lim;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpe_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_div_cnt <= n_div_cnt;
        r_div_im  <= n_div_im;
        r_re_neg  <= n_re_neg;
        r_im_neg  <= n_im_neg;
        r_im_mag  <= n_im_mag;
        r_cr      <= n_cr;
        r_ci      <= n_ci;
        r_zr      <= n_zr;
        r_zi      <= n_zi;
        r_sr      <= n_sr;
        r_si      <= n_si;
        r_pr      <= n_pr;
        r_op      <= n_op;
        r_a_mag   <= n_a_mag;
        r_b_mag   <= n_b_mag;
        r_mneg    <= n_mneg;
        r_ia      <= n_ia;
        r_ib      <= n_ib;
        r_mul_fin <= n_mul_fin;
        r_pp      <= n_pp;
        r_pp_sh   <= n_pp_sh;
        r_pp_vld  <= n_pp_vld;
        r_acc     <= n_acc;
        r_cnt     <= n_cnt;
        r_out     <= n_out;
    end

endmodule

>>> src/mpe_checker.sv
`include "mandelbrot_pixel_escape_macros.svh"

module mpe_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_pix_valid,
    input logic             i_pix_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input mpe_pkg::t_result i_res_payload,
    input logic             i_cfg_valid,
    input logic             i_cfg_ready,
    input mpe_pkg::t_cfg_wr i_cfg_payload
);

    logic [mpe_pkg::LIM_W-1:0] r_lim;
    mpe_pkg::t_result          r_res_payload;
    logic                      pix_acc;
    logic                      res_stall;
    logic                      res_held;
    logic                      inside_ok;
    logic                      count_ok;

    // mirror the iteration limit from the write channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= mpe_pkg::RST_ITERATION_LIMIT;
        end else if (i_cfg_valid && i_cfg_ready &&
                     (i_cfg_payload.index == mpe_pkg::REG_ITERATION_LIMIT)) begin
            r_lim <= i_cfg_payload.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_payload <= i_res_payload;
    end

    assign pix_acc   = i_pix_valid && i_pix_ready;
    assign res_stall = i_res_valid && !i_res_ready;
    assign res_held  = i_res_valid && (i_res_payload == r_res_payload);
    assign inside_ok = i_res_payload.inside_set == (i_res_payload.escape_count == r_lim);
    assign count_ok  = (i_res_payload.escape_count != '0) &&
                       ((i_res_payload.escape_count <= r_lim) ||
                        (i_res_payload.escape_count == mpe_pkg::CNT_W'(1)));

    `MPE_ASSERT_NEXT(a_busy, i_clk, i_rst_n, pix_acc, !i_pix_ready, "pixel ready while busy")

    `MPE_ASSERT_SAME(a_inside, i_clk, i_rst_n, i_res_valid, inside_ok, "inside flag mismatch")

    `MPE_ASSERT_SAME(a_count, i_clk, i_rst_n, i_res_valid, count_ok, "escape count out of range")

    `MPE_ASSERT_NEXT(a_held, i_clk, i_rst_n, res_stall, res_held, "stalled result changed")

endmodule

bind mandelbrot_pixel_escape mpe_checker u_mpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_pix_valid   (i_pix.valid),
    .i_pix_ready   (i_pix.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_payload (o_res.payload),
    .i_cfg_valid   (i_cfg.valid),
    .i_cfg_ready   (i_cfg.ready),
    .i_cfg_payload (i_cfg.payload)
);

>>> tb/sv/mpe_escape_checker.sv
`timescale 1ns / 100ps

module mpe_escape_checker
    import mpe_pkg::*;
#(
    parameter int FRAC_BITS = 28
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_pix_valid,
    input  logic    i_pix_ready,
    input  t_pixel  i_pix,
    input  logic    i_res_valid,
    input  logic    i_res_ready,
    input  t_result i_res,
    input  logic    i_cfg_valid,
    input  logic    i_cfg_ready,
    input  t_cfg_wr i_cfg,
    output int      o_pending,
    output int      o_errors,
    output int      o_checked,
    output int      o_inside
);

    localparam longint Q_HI = (longint'(1) << (FRAC_BITS + 3)) - 1;
    localparam longint Q_LO = -(longint'(1) << (FRAC_BITS + 3));

    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic [LIM_W-1:0] cfg_limit;
    t_result          expected_results[$];
    int               err_cnt;
    int               chk_cnt;
    int               in_cnt;

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned p;
        ma = (a < 0) ? longint'(-a) : longint'(a);
        mb = (b < 0) ? longint'(-b) : longint'(b);
        p  = (ma * mb) >> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint map_axis(input longint offs, input longint unsigned div);
        longint unsigned m;
        longint unsigned q;
        m = (offs < 0) ? longint'(-offs) : longint'(offs);
        if (m / div >= 8) return (offs < 0) ? Q_LO : Q_HI;
        q = (m << FRAC_BITS) / div;
        return (offs < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_result escape_time(input t_pixel px);
        longint unsigned qw;
        longint unsigned qh;
        longint          cr;
        longint          ci;
        longint          zr;
        longint          zi;
        longint          sr;
        longint          si;
        longint          pr;
        int unsigned     n;
        bit              done;
        t_result         r;
        qw = longint'(cfg_width >> 2);
        qh = longint'(cfg_height >> 1);
        if (qw == 0) qw = 1;
        if (qh == 0) qh = 1;
        cr = map_axis(longint'(px.pixel_col) - longint'(cfg_width >> 1), qw);
        ci = map_axis(longint'(px.pixel_row) - longint'(cfg_height >> 1), qh);
        zr   = 0;
        zi   = 0;
        n    = 0;
        done = 1'b0;
        while (!done) begin
            sr = fix_mul(zr, zr);
            si = fix_mul(zi, zi);
            if (sr + si >= (longint'(4) << FRAC_BITS)) begin
                done = 1'b1;
            end else begin
                n++;
                if (n >= int'(cfg_limit)) begin
                    done = 1'b1;
                end else begin
                    pr = fix_mul(zr, zi);
                    zr = clamp_q(sr - si + cr);
                    zi = clamp_q(2 * pr + ci);
                end
            end
        end
        r.inside_set   = (n == int'(cfg_limit));
        r.escape_count = n[CNT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        err_cnt++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg_width  = RST_IMAGE_WIDTH;
            cfg_height = RST_IMAGE_HEIGHT;
            cfg_limit  = RST_ITERATION_LIMIT;
            expected_results.delete();
            err_cnt = 0;
            chk_cnt = 0;
            in_cnt  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg.index)
                    REG_IMAGE_WIDTH:     cfg_width  = i_cfg.data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT:    cfg_height = i_cfg.data[DIM_W-1:0];
                    REG_ITERATION_LIMIT: cfg_limit  = i_cfg.data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected result, escape_count", -1,
                                  int'(i_res.escape_count));
                end else begin
                    want = expected_results.pop_front();
                    chk_cnt++;
                    if (want.inside_set) in_cnt++;
                    if (i_res.inside_set !== want.inside_set)
                        flag_mismatch("inside_set", int'(want.inside_set),
                                      int'(i_res.inside_set));
                    if (i_res.escape_count !== want.escape_count)
                        flag_mismatch("escape_count", int'(want.escape_count),
                                      int'(i_res.escape_count));
                end
            end
            if (i_pix_valid && i_pix_ready)
                expected_results.push_back(escape_time(i_pix));
        end
        o_pending <= expected_results.size();
        o_errors  <= err_cnt;
        o_checked <= chk_cnt;
        o_inside  <= in_cnt;
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import mpe_pkg::*;

    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int TAIL_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;

    mpe_stream_if #(.T_PAYLOAD(t_pixel))  pix_if ();
    mpe_stream_if #(.T_PAYLOAD(t_result)) res_if ();
    mpe_stream_if #(.T_PAYLOAD(t_cfg_wr)) cfg_if ();

    int pending;
    int errors;
    int checked;
    int inside_cnt;
    int snd_idle;
    int rcv_stall;
    int settings;
    int cycle_cnt;

    mandelbrot_pixel_escape uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    mpe_escape_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (pix_if.valid),
        .i_pix_ready (pix_if.ready),
        .i_pix       (pix_if.payload),
        .i_res_valid (res_if.valid),
        .i_res_ready (res_if.ready),
        .i_res       (res_if.payload),
        .i_cfg_valid (cfg_if.valid),
        .i_cfg_ready (cfg_if.ready),
        .i_cfg       (cfg_if.payload),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_checked   (checked),
        .o_inside    (inside_cnt)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= rcv_stall);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // hold valid low for the sender's idle cycles, then present one transaction
    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        while ($urandom_range(99) < snd_idle) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.payload <= '{pixel_col: col, pixel_row: row};
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    task automatic drain();
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] lim);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_ITERATION_LIMIT, lim);
        cfg_if.valid <= 1'b0;
        settings++;
    endtask

    // mostly pixels inside the image, the rest anywhere in the field range
    task automatic send_random_pixel(input int w, input int h);
        int col;
        int row;
        if (w == 0 || $urandom_range(4) == 0)
            col = $urandom_range(0, 4095);
        else
            col = $urandom_range(0, ((w > 4096) ? 4096 : w) - 1);
        if (h == 0 || $urandom_range(4) == 0)
            row = $urandom_range(0, 4095);
        else
            row = $urandom_range(0, ((h > 4096) ? 4096 : h) - 1);
        send_pixel(col[COL_W-1:0], row[ROW_W-1:0]);
    endtask

    initial begin
        int w;
        int h;
        int lim;
        pix_if.valid   <= 1'b0;
        pix_if.payload <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        i_rst_n        <= 1'b0;
        snd_idle  = 0;
        rcv_stall = 0;
        settings  = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: far corners escape at once
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        drain();

        // small width, small height, zero limit
        configure(16'd3, 16'd1, 16'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd2, 12'd1);
        send_pixel(12'd3, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain();

        // upper data bits dropped: width 8191, height 0; limit one
        configure(16'hffff, 16'he000, 16'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd1);
        send_pixel(12'd2047, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain();

        // smallest image, largest limit, saturated c
        configure(16'd4, 16'd2, 16'hffff);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'd5, 12'd0);
        send_pixel(12'd0, 12'd3);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'haaa, 12'h555);
        drain();

        configure(16'd4096, 16'd4096, 16'd30000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd3072, 12'd2048);
        send_pixel(12'd4095, 12'd4095);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 81; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 81; end
                default: begin snd_idle = 14; rcv_stall = 14; end
            endcase
            for (int blk = 0; blk < 3; blk++) begin
                w   = ($urandom_range(7) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(4, 600);
                h   = ($urandom_range(7) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(2, 600);
                lim = ($urandom_range(9) == 0) ? $urandom_range(0, 3)
                                               : $urandom_range(1, 255);
                configure(w[CFG_DATA_W-1:0], h[CFG_DATA_W-1:0], lim[CFG_DATA_W-1:0]);
                for (int k = 0; k < 8; k++)
                    send_random_pixel(w, h);
                drain();
            end
        end

        snd_idle  = 0;
        rcv_stall = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d pixels under %0d register settings, %0d of them in the set.",
                 checked, settings, inside_cnt);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
